// ===== rtl/sharpen_3x3_cross_stream_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sharpen stream block
// Short forms for clocked implication checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef SHARPEN_3X3_CROSS_STREAM_MACROS_SVH
`define SHARPEN_3X3_CROSS_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SH3_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SH3_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/sh3x3_pkg.sv =====
// ---------------------------------------------------------------------------
// Sharpen stream package
// Field widths, register codes, reset values and the result record.
// ---------------------------------------------------------------------------
package sh3x3_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int ROW_W     = 12;
   localparam int INDEX_W   = 13;
   localparam int LEN_W     = 14;
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 13;
   localparam int CHAN_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam int ACC_W     = 12;

   localparam int LINE_SAMPLES_DEF = 8192;
   localparam int MAX_CHANNELS_DEF = 4;

   localparam int WIDTH_MAX   = 2048;
   localparam int HEIGHT_MAX  = 4096;
   localparam int SHARP_GAIN  = 5;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CHAN_W-1:0]   CHAN_RESET   = 3'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]    out_row;
      logic [INDEX_W-1:0]  out_index;
      logic [SAMPLE_W-1:0] out_value;
      logic                is_filtered;
      logic                last_of_run;
   } result_type;

endpackage

// ===== rtl/sh3x3_channels.sv =====
// ---------------------------------------------------------------------------
// Sharpen stream channels
// Request, response and register-write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sh3x3_req_if import sh3x3_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface sh3x3_rsp_if import sh3x3_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ROW_W-1:0]    out_row;
   logic [INDEX_W-1:0]  out_index;
   logic [SAMPLE_W-1:0] out_value;
   logic                is_filtered;
   logic                last_of_run;

   modport source (output valid, output out_row, output out_index, output out_value,
                   output is_filtered, output last_of_run, input ready);
   modport sink   (input valid, input out_row, input out_index, input out_value,
                   input is_filtered, input last_of_run, output ready);
endinterface

interface sh3x3_csr_if import sh3x3_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sh3x3_ram.sv =====
// ---------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and two read ports, registered read data, read returns
// the contents from before a write to the same address in the same cycle.
// ---------------------------------------------------------------------------
module sh3x3_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 8192,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/sharpen_3x3_cross_stream.sv =====
// ---------------------------------------------------------------------------
// 3x3 cross sharpening filter over a raster sample stream
// Samples arrive one channel at a time in raster order. Every interior sample
// of the frame becomes 5*center minus its up, down, left and right neighbours
// of the same channel, clamped to 0..255; samples on the frame border pass
// through unchanged. Results for a row come out while the next row arrives,
// tagged with their row and sample index, so output runs one row behind the
// input. A request in row zero gives no result (unless the frame is one row
// tall), a request in a middle row gives one, and a request in the last row
// gives two: the row above, then its own pass-through. Requests are taken one
// per cycle while the result queue has room; in the last row each request
// gives two results but the response port drains one per cycle, so input
// stalls. A result is registered in stage B, then in the result queue, before
// it is presented. The two previous rows live in a single line store RAM, one
// entry per sample index, holding both rows side by side; it is read at the
// center and right-neighbour index in the cycle a request is accepted and
// written back the next cycle, so the line store port pair is what sets the
// one-request-per-cycle pace. Line store contents are undefined after reset
// and are not cleared; the rows fill as the first frame streams in. Register
// writes take effect on the next request and are meant for an idle block.
// ---------------------------------------------------------------------------
`include "sharpen_3x3_cross_stream_macros.svh"

module sharpen_3x3_cross_stream import sh3x3_pkg::*; #(
   parameter int LINE_SAMPLES = LINE_SAMPLES_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sh3x3_req_if.sink  req_ch,
   sh3x3_rsp_if.source rsp_ch,
   sh3x3_csr_if.sink  csr_ch
);

   // Line store address width and the index width of the recent-sample row.
   localparam int AW    = (LINE_SAMPLES > 1) ? $clog2(LINE_SAMPLES) : 1;
   localparam int RI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int MEM_W = 2 * SAMPLE_W;

   // -----------------------------------------------------------------------
   // Configuration registers
   // -----------------------------------------------------------------------
   logic [WIDTH_W-1:0]  cfg_width_ff;
   logic [HEIGHT_W-1:0] cfg_height_ff;
   logic [CHAN_W-1:0]   cfg_chan_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
         cfg_chan_ff   <= CHAN_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_IMAGE_WIDTH:   cfg_width_ff  <= csr_ch.data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_height_ff <= csr_ch.data[HEIGHT_W-1:0];
            CSR_CHANNEL_COUNT: cfg_chan_ff   <= csr_ch.data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Registers are used clamped to their legal ranges. The row length is
   // pixels times channels, capped by the line store depth.
   logic [WIDTH_W-1:0]  w_use;
   logic [HEIGHT_W-1:0] h_use;
   logic [CHAN_W-1:0]   ch_use;
   logic [LEN_W-1:0]    len_raw;
   logic [LEN_W-1:0]    len_use;

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_use = WIDTH_W'(1);
      end else if (int'(cfg_width_ff) > WIDTH_MAX) begin
         w_use = WIDTH_W'(WIDTH_MAX);
      end else begin
         w_use = cfg_width_ff;
      end

      if (cfg_height_ff == '0) begin
         h_use = HEIGHT_W'(1);
      end else if (int'(cfg_height_ff) > HEIGHT_MAX) begin
         h_use = HEIGHT_W'(HEIGHT_MAX);
      end else begin
         h_use = cfg_height_ff;
      end

      if (cfg_chan_ff == '0) begin
         ch_use = CHAN_W'(1);
      end else if (int'(cfg_chan_ff) > MAX_CHANNELS) begin
         ch_use = CHAN_W'(MAX_CHANNELS);
      end else begin
         ch_use = cfg_chan_ff;
      end

      len_raw = LEN_W'(w_use) * LEN_W'(ch_use);
      if (int'(len_raw) > LINE_SAMPLES) begin
         len_use = LEN_W'(LINE_SAMPLES);
      end else begin
         len_use = len_raw;
      end
   end

   // -----------------------------------------------------------------------
   // Stage A: position of the incoming request and line store read
   // -----------------------------------------------------------------------
   logic [ROW_W-1:0]   row_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [ROW_W-1:0]   row_in;
   logic [INDEX_W-1:0] idx_in;

   logic [HEIGHT_W-1:0] r_pos;
   logic [LEN_W-1:0]    c_pos;
   logic [HEIGHT_W-1:0] r_nxt;
   logic [LEN_W-1:0]    c_nxt;
   logic [LEN_W-1:0]    c_right;
   logic                a_above;
   logic                a_own;
   logic                a_inner;
   logic [AW-1:0]       a_addr;
   logic [AW-1:0]       a_addr_right;
   logic                accept;

   always_comb begin
      r_pos = {1'b0, row_ff};
      c_pos = {1'b0, idx_ff};
      if (req_ch.frame_start) begin
         r_pos = '0;
         c_pos = '0;
      end
      // A position left past the row end by a register change wraps first.
      if (c_pos >= len_use) begin
         c_pos = '0;
         r_pos = r_pos + HEIGHT_W'(1);
      end
      if (r_pos >= h_use) begin
         r_pos = '0;
      end

      c_nxt = c_pos + LEN_W'(1);
      r_nxt = r_pos;
      if (c_nxt >= len_use) begin
         c_nxt = '0;
         r_nxt = r_pos + HEIGHT_W'(1);
         if (r_nxt >= h_use) begin
            r_nxt = '0;
         end
      end
      row_in = r_nxt[ROW_W-1:0];
      idx_in = c_nxt[INDEX_W-1:0];

      c_right = c_pos + LEN_W'(ch_use);
      a_above = (r_pos != '0);
      a_own   = (r_pos == h_use - HEIGHT_W'(1));
      a_inner = (r_pos >= HEIGHT_W'(2)) && (c_pos >= LEN_W'(ch_use)) && (c_right < len_use);

      a_addr = AW'(c_pos);
      if (int'(c_right) < LINE_SAMPLES) begin
         a_addr_right = AW'(c_right);
      end else begin
         a_addr_right = '0;
      end
   end

   // -----------------------------------------------------------------------
   // Stage B registers, forwarding and result queue state
   // -----------------------------------------------------------------------
   logic                b_valid_ff;
   logic                b_above_ff;
   logic                b_own_ff;
   logic                b_inner_ff;
   logic [ROW_W-1:0]    b_row_ff;
   logic [INDEX_W-1:0]  b_idx_ff;
   logic [SAMPLE_W-1:0] b_sample_ff;
   logic [AW-1:0]       b_addr_ff;

   logic                fwd_c_ff;
   logic                fwd_r_ff;
   logic [MEM_W-1:0]    fwd_data_ff;

   logic [SAMPLE_W-1:0] recent_ff [MAX_CHANNELS];

   result_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   head_ff;
   logic [FIFO_PTR_W-1:0]   tail_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   logic [1:0] b_n;
   assign b_n = b_valid_ff ? ({1'b0, b_above_ff} + {1'b0, b_own_ff}) : 2'd0;

   // Room is reserved for the worst case of the incoming request (two results)
   // on top of the results already queued and those about to leave stage B.
   assign req_ch.ready = (FIFO_CNT_W'(count_ff) + FIFO_CNT_W'(b_n))
                         <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign accept = req_ch.valid && req_ch.ready;

   // -----------------------------------------------------------------------
   // Line store: high byte holds the row two above, low byte the row above.
   // -----------------------------------------------------------------------
   logic             mem_wr_en;
   logic [MEM_W-1:0] mem_wr_data;
   logic [MEM_W-1:0] q_center;
   logic [MEM_W-1:0] q_right;

   sh3x3_ram #(
      .WIDTH (MEM_W),
      .DEPTH (LINE_SAMPLES)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (b_addr_ff),
      .wr_data   (mem_wr_data),
      .rd_en     (accept),
      .rd_addr_a (a_addr),
      .rd_addr_b (a_addr_right),
      .rd_data_a (q_center),
      .rd_data_b (q_right)
   );

   // -----------------------------------------------------------------------
   // Stage B: filter arithmetic and write-back
   // -----------------------------------------------------------------------
   logic [SAMPLE_W-1:0] up_val;
   logic [SAMPLE_W-1:0] center_val;
   logic [SAMPLE_W-1:0] right_val;
   logic [SAMPLE_W-1:0] left_val;
   logic [RI_W-1:0]     left_sel;
   logic [SAMPLE_W+2:0] center_x5;
   logic [SAMPLE_W+1:0] cross_sum;
   logic signed [ACC_W-1:0] acc;
   logic [SAMPLE_W-1:0] sharp_val;
   result_type          res_above;
   result_type          res_own;
   result_type          res_first;

   always_comb begin
      // The write in the previous cycle went to the RAM after its read, so a
      // matching address takes the written data instead.
      if (fwd_c_ff) begin
         up_val     = fwd_data_ff[MEM_W-1:SAMPLE_W];
         center_val = fwd_data_ff[SAMPLE_W-1:0];
      end else begin
         up_val     = q_center[MEM_W-1:SAMPLE_W];
         center_val = q_center[SAMPLE_W-1:0];
      end
      right_val = fwd_r_ff ? fwd_data_ff[SAMPLE_W-1:0] : q_right[SAMPLE_W-1:0];
      left_sel  = RI_W'(ch_use - CHAN_W'(1));
      left_val  = recent_ff[left_sel];

      center_x5 = ({3'b000, center_val} << 2) + {3'b000, center_val};
      cross_sum = {2'b00, up_val} + {2'b00, b_sample_ff}
                + {2'b00, left_val} + {2'b00, right_val};
      acc       = signed'(ACC_W'(center_x5)) - signed'(ACC_W'(cross_sum));
      if (acc < 0) begin
         sharp_val = '0;
      end else if (acc > signed'(ACC_W'(255))) begin
         sharp_val = '1;
      end else begin
         sharp_val = acc[SAMPLE_W-1:0];
      end

      res_above.out_row     = b_row_ff - ROW_W'(1);
      res_above.out_index   = b_idx_ff;
      res_above.out_value   = b_inner_ff ? sharp_val : center_val;
      res_above.is_filtered = b_inner_ff;
      res_above.last_of_run = !b_own_ff;

      res_own.out_row     = b_row_ff;
      res_own.out_index   = b_idx_ff;
      res_own.out_value   = b_sample_ff;
      res_own.is_filtered = 1'b0;
      res_own.last_of_run = 1'b1;

      res_first = b_above_ff ? res_above : res_own;
   end

   assign mem_wr_en   = b_valid_ff;
   assign mem_wr_data = {center_val, b_sample_ff};

   // -----------------------------------------------------------------------
   // Control and payload registers
   // -----------------------------------------------------------------------
   logic pop;
   assign pop = (count_ff != '0) && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         idx_ff     <= '0;
         b_valid_ff <= 1'b0;
         fwd_c_ff   <= 1'b0;
         fwd_r_ff   <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            recent_ff[i] <= '0;
         end
      end else begin
         b_valid_ff <= accept;
         if (accept) begin
            row_ff   <= row_in;
            idx_ff   <= idx_in;
            fwd_c_ff <= b_valid_ff && (a_addr == b_addr_ff);
            fwd_r_ff <= b_valid_ff && (a_addr_right == b_addr_ff);
         end
         if (b_valid_ff) begin
            for (int i = MAX_CHANNELS - 1; i > 0; i--) begin
               recent_ff[i] <= recent_ff[i-1];
            end
            recent_ff[0] <= center_val;
         end
         if (pop) begin
            head_ff <= head_ff + FIFO_PTR_W'(1);
         end
         tail_ff  <= tail_ff + FIFO_PTR_W'(b_n);
         count_ff <= count_ff + FIFO_CNT_W'(b_n) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_above_ff  <= a_above;
         b_own_ff    <= a_own;
         b_inner_ff  <= a_inner;
         b_row_ff    <= r_pos[ROW_W-1:0];
         b_idx_ff    <= c_pos[INDEX_W-1:0];
         b_sample_ff <= req_ch.sample;
         b_addr_ff   <= a_addr;
         fwd_data_ff <= mem_wr_data;
      end
      if (b_n != 2'd0) begin
         fifo_ff[tail_ff] <= res_first;
      end
      if (b_n == 2'd2) begin
         fifo_ff[tail_ff + FIFO_PTR_W'(1)] <= res_own;
      end
   end

   // -----------------------------------------------------------------------
   // Response port
   // -----------------------------------------------------------------------
   assign rsp_ch.valid       = (count_ff != '0);
   assign rsp_ch.out_row     = fifo_ff[head_ff].out_row;
   assign rsp_ch.out_index   = fifo_ff[head_ff].out_index;
   assign rsp_ch.out_value   = fifo_ff[head_ff].out_value;
   assign rsp_ch.is_filtered = fifo_ff[head_ff].is_filtered;
   assign rsp_ch.last_of_run = fifo_ff[head_ff].last_of_run;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   // The forward flags keep their value between requests and only count in
   // the cycle right after an accepted request.
   `SH3_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, int'(count_ff) <= FIFO_DEPTH, "result queue overfilled")
   `SH3_ASSERT_IMP(a_push_room, clock, reset, b_valid_ff, (int'(count_ff) + int'(b_n)) <= FIFO_DEPTH, "no room for stage B results")
   `SH3_ASSERT_IMP(a_fwd_source, clock, reset, (b_valid_ff && (fwd_c_ff || fwd_r_ff)), $past(b_valid_ff), "forward flag without a prior write")
   `SH3_ASSERT_IMP(a_row0_silent, clock, reset, (b_valid_ff && !b_above_ff), (b_row_ff == '0), "missing row-above result outside row zero")

endmodule

// ===== tb/sh3x3_sharpen_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sharpen stream result checker
// Watches the request, response and register-write channels, keeps its own
// copy of the filter state, and compares each result against the oldest
// predicted result, field by field.
// ---------------------------------------------------------------------------
module sh3x3_sharpen_checker import sh3x3_pkg::*; (
   input  logic clock,
   input  logic reset,
   sh3x3_req_if req_mon,
   sh3x3_rsp_if rsp_mon,
   sh3x3_csr_if csr_mon,
   output int   mismatch_count,
   output int   results_outstanding
);

   logic [WIDTH_W-1:0]  width_cfg;
   logic [HEIGHT_W-1:0] height_cfg;
   logic [CHAN_W-1:0]   chan_cfg;

   // Rows r-1 and r-2 of the frame, and the row r-1 values pushed out of the
   // upper store by the latest requests, newest first.
   logic [SAMPLE_W-1:0] row_above      [LINE_SAMPLES_DEF];
   logic [SAMPLE_W-1:0] row_two_up     [LINE_SAMPLES_DEF];
   logic [SAMPLE_W-1:0] displaced_hist [MAX_CHANNELS_DEF];
   int unsigned         row_pos;
   int unsigned         index_pos;

   result_type          sharpened_queue [$];
   result_type          seen;
   int                  mismatches = 0;

   function automatic int unsigned limit_to(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_sharpened(input logic [SAMPLE_W-1:0] smp, input logic fs);
      int unsigned w, h, ch, len, r, c, i;
      int          acc;
      logic [SAMPLE_W-1:0] center;
      result_type  res;
      w   = limit_to(width_cfg, 1, WIDTH_MAX);
      h   = limit_to(height_cfg, 1, HEIGHT_MAX);
      ch  = limit_to(chan_cfg, 1, MAX_CHANNELS_DEF);
      len = w * ch;
      if (len > LINE_SAMPLES_DEF) len = LINE_SAMPLES_DEF;
      if (fs) begin
         row_pos   = 0;
         index_pos = 0;
      end
      if (index_pos >= len) begin
         index_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = index_pos;
      center = row_above[c];

      if (r >= 1) begin
         res.out_row     = ROW_W'(r - 1);
         res.out_index   = INDEX_W'(c);
         res.last_of_run = (r != h - 1);
         if (r >= 2 && c >= ch && c + ch < len) begin
            acc = SHARP_GAIN * int'(center)
                  - (int'(row_two_up[c]) + int'(smp) + int'(displaced_hist[ch - 1])
                     + int'(row_above[c + ch]));
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            res.out_value   = SAMPLE_W'(acc);
            res.is_filtered = 1'b1;
         end else begin
            res.out_value   = center;
            res.is_filtered = 1'b0;
         end
         sharpened_queue.push_back(res);
      end
      if (r == h - 1) begin
         res.out_row     = ROW_W'(r);
         res.out_index   = INDEX_W'(c);
         res.out_value   = smp;
         res.is_filtered = 1'b0;
         res.last_of_run = 1'b1;
         sharpened_queue.push_back(res);
      end

      for (i = MAX_CHANNELS_DEF - 1; i > 0; i--) displaced_hist[i] = displaced_hist[i - 1];
      displaced_hist[0] = center;
      row_two_up[c]     = center;
      row_above[c]      = smp;

      index_pos = c + 1;
      row_pos   = r;
      if (index_pos >= len) begin
         index_pos = 0;
         row_pos   = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_result(input result_type got);
      result_type want;
      if (sharpened_queue.size() == 0) begin
         $error("result with nothing pending: out_row %0d, out_index %0d",
                got.out_row, got.out_index);
         mismatches++;
         return;
      end
      want = sharpened_queue.pop_front();
      compare_field("out_row", want.out_row, got.out_row);
      compare_field("out_index", want.out_index, got.out_index);
      compare_field("out_value", want.out_value, got.out_value);
      compare_field("is_filtered", want.is_filtered, got.is_filtered);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_cfg  = WIDTH_RESET;
         height_cfg = HEIGHT_RESET;
         chan_cfg   = CHAN_RESET;
         foreach (row_above[i]) begin
            row_above[i]  = '0;
            row_two_up[i] = '0;
         end
         foreach (displaced_hist[i]) displaced_hist[i] = '0;
         row_pos   = 0;
         index_pos = 0;
         sharpened_queue.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_IMAGE_WIDTH:   width_cfg  = csr_mon.data[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT:  height_cfg = csr_mon.data[HEIGHT_W-1:0];
               CSR_CHANNEL_COUNT: chan_cfg   = csr_mon.data[CHAN_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_sharpened(req_mon.sample, req_mon.frame_start);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.out_row     = rsp_mon.out_row;
            seen.out_index   = rsp_mon.out_index;
            seen.out_value   = rsp_mon.out_value;
            seen.is_filtered = rsp_mon.is_filtered;
            seen.last_of_run = rsp_mon.last_of_run;
            check_result(seen);
         end
      end
      mismatch_count      <= mismatches;
      results_outstanding <= sharpened_queue.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sharpen stream testbench top
// Drives sample requests and register writes into the 3x3 cross sharpening
// block, throttles the response side, and reports the verdict from the
// result checker that sits beside the block.
// ---------------------------------------------------------------------------
module tb_top;
   import sh3x3_pkg::*;

   // The watchdog limit covers the slowest legal run many times over: every
   // request waiting out a full idle burst, two results per request each
   // stalled by a full receiver burst, plus the long hold-off and the pauses
   // between register phases.
   localparam int CYCLE_LIMIT      = 400000;
   localparam int ITEM_TARGET      = 1050;
   localparam int TAIL_START       = 880;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_SETTLE      = 8;
   localparam int END_SETTLE       = 16;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_outstanding;

   // Stimulus bookkeeping shared with the receiver process.
   int   items_sent     = 0;
   int   req_gap_rate   = 0;
   bit   quiet_tail     = 1'b0;
   bit   long_hold_req  = 1'b0;
   bit   long_hold_done = 1'b0;

   sh3x3_req_if req_ch ();
   sh3x3_rsp_if rsp_ch ();
   sh3x3_csr_if csr_ch ();

   sharpen_3x3_cross_stream i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sh3x3_sharpen_checker i_sharpen_check (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_ch),
      .rsp_mon             (rsp_ch),
      .csr_mon             (csr_ch),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly random samples, with a fair share of the two extremes so that
   // both clamp limits get hit often in the interior.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one request and returns at the edge that accepts it. Valid stays
   // high afterwards so back-to-back requests need no extra edge; an idle
   // burst, when drawn, drops valid first.
   task automatic send_request(input logic [SAMPLE_W-1:0] smp, input logic fs);
      if (!quiet_tail && $urandom_range(0, 15) < req_gap_rate) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= smp;
      req_ch.frame_start <= fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (items_sent >= TAIL_START) quiet_tail = 1'b1;
   endtask

   // Stops offering, waits for every predicted result to come back, then
   // leaves a few more cycles for work on requests that produce no result
   // (row zero) so the block is truly idle before the next register write.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Valid is left high on return; the caller lowers it after its last write.
   task automatic write_register(input csr_index_type idx, input int unsigned value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DAT_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w_val, input int unsigned h_val,
                               input int unsigned ch_val);
      write_register(CSR_IMAGE_WIDTH, w_val);
      write_register(CSR_IMAGE_HEIGHT, h_val);
      write_register(CSR_CHANNEL_COUNT, ch_val);
      csr_ch.valid <= 1'b0;
   endtask

   // Response side. Ready drops in random bursts of randomly changing density,
   // a density of zero giving long stretches with no stalls. Once, on request
   // from the stimulus, ready is held low for a long stretch while requests keep
   // coming, so the block backs up and stalls its input.
   initial begin : result_drain
      int          drain_rate;
      int unsigned tick;
      rsp_ch.ready = 1'b0;
      drain_rate   = 0;
      tick         = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 64 == 0) drain_rate = $urandom_range(0, 3) * 2;
         if (long_hold_req && !long_hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 15) < drain_rate) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] hot_center  [9];
      logic [SAMPLE_W-1:0] dark_center [9];
      int unsigned k, count, w, h, ch;

      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.frame_start = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_IMAGE_WIDTH;
      csr_ch.data        = '0;
      reset              = 1'b1;

      // A bright center under bright neighbours overshoots 255; a dark
      // center ringed by full-scale samples undershoots 0.
      hot_center  = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
      dark_center = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A 3x3 single-channel frame gives a row-zero request
      // with no result, a middle row with one result per request and a last
      // row with two. The second frame follows without a frame start flag,
      // so the position must wrap to row zero by itself.
      set_geometry(3, 3, 1);
      for (k = 0; k < 9; k++) send_request(hot_center[k], k == 0);
      for (k = 0; k < 9; k++) send_request(dark_center[k], 1'b0);
      wait_drained();

      // One-row frame: every request returns its own pass-through. Height is
      // written as zero and the channel count as seven, both out of range.
      set_geometry(2, 0, 7);
      send_request('0, 1'b1);
      send_request('1, 1'b0);
      send_request(pick_sample(), 1'b0);
      wait_drained();

      // Widest row the block allows, kept to one row so only a few requests
      // are needed; the width value is past the top of its range.
      set_geometry(4095, 1, 4);
      send_request('1, 1'b1);
      send_request('0, 1'b0);
      wait_drained();

      // Tallest frame (height written past its range) with one-sample rows
      // and a channel count of zero.
      set_geometry(1, 8191, 0);
      for (k = 0; k < 5; k++) send_request(pick_sample(), k == 0);
      wait_drained();

      // Register changes in the middle of a frame. Two full rows at a
      // 12-sample row length fill the line store, then the row is shortened
      // while the position sits beyond the new end, forcing a wrap to the
      // next row, and later the height drops below the current row, forcing
      // a wrap to row zero. The long receiver hold-off happens here, while
      // the sender offers requests with no gaps.
      req_gap_rate  = 0;
      long_hold_req = 1'b1;
      set_geometry(6, 5, 2);
      for (k = 0; k < 31; k++) send_request(pick_sample(), k == 0);
      wait_drained();
      write_register(CSR_IMAGE_WIDTH, 2);
      csr_ch.valid <= 1'b0;
      for (k = 0; k < 6; k++) send_request(pick_sample(), 1'b0);
      wait_drained();
      write_register(CSR_IMAGE_HEIGHT, 3);
      csr_ch.valid <= 1'b0;
      for (k = 0; k < 12; k++) send_request(pick_sample(), 1'b0);
      wait_drained();

      // Random part. Each phase picks a small geometry, writes it (sometimes
      // through an out-of-range value that clamps to the same geometry) and
      // streams one or two frames, now and then cut short. Every phase opens
      // with a frame start so the line store is refilled from row zero; a
      // stray frame start now and then restarts the frame mid-stream. The
      // last phase is trimmed so the run stops at the request target.
      while (items_sent < ITEM_TARGET) begin
         w  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         h  = $urandom_range(1, 6);
         ch = $urandom_range(1, 4);
         set_geometry((w == 1 && $urandom_range(0, 1) == 1) ? 0 : w,
                      (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h,
                      (ch == 4 && $urandom_range(0, 1) == 1) ? $urandom_range(5, 7) :
                      (ch == 1 && $urandom_range(0, 1) == 1) ? 0 : ch);
         req_gap_rate = $urandom_range(0, 2) * 3;
         count = w * ch * h * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         if (count > ITEM_TARGET - items_sent) count = ITEM_TARGET - items_sent;
         for (k = 0; k < count; k++) begin
            send_request(pick_sample(), k == 0 || $urandom_range(0, 63) == 0);
         end
         wait_drained();
      end

      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sh3x3_pkg.sv
rtl/sh3x3_channels.sv
rtl/sh3x3_ram.sv
rtl/sharpen_3x3_cross_stream.sv
tb/sh3x3_sharpen_checker.sv
tb/tb_top.sv
